/* rtl/core/wn_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the Walsh nonlinearity block.
// No dependencies; imported by wn_dp, wn_ctrl, walsh_nonlinearity and the bench.
package wn_pkg;

  localparam int MAX_VARS_DEF   = 10;
  localparam int NUM_VARS_W     = 4;
  localparam logic [NUM_VARS_W-1:0] NUM_VARS_RST = 4'd4;

  // Configuration map: byte address 4*index, index = paddr[2]
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;
  localparam logic REG_NUM_VARS = 1'b0;

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  typedef struct packed {
    logic load;       // write the accepted bit into the table
    logic scan_init;  // clear scan counters and running maximum
    logic step;       // issue one table read for the current (w, x)
    logic emit;       // capture the result into the output registers
  } cmd_t;

  typedef struct packed {
    logic last_bit;   // the bit at hand completes the table
    logic scan_last;  // current (w, x) is the final pair
    logic idle;       // scan pipeline holds nothing in flight
  } status_t;

endpackage

/* rtl/core/wn_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wn_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/wn_dp.sv */
`timescale 1ns / 1ps
// Datapath: truth-table store, bit counter, Walsh scan pipeline, result registers.
// Depends on wn_pkg and wn_ram.
module wn_dp
  import wn_pkg::*;
#(
  parameter int MAX_VARS = MAX_VARS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [NUM_VARS_W-1:0] num_vars,
  input  logic                  truth_bit,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic [MAX_VARS-1:0]   nonlinearity,
  output logic [MAX_VARS:0]     max_abs_walsh
);

  localparam int AW = MAX_VARS;
  localparam int CW = MAX_VARS + 1;
  localparam int NW = $clog2(MAX_VARS + 1);

  logic [NW-1:0] n_eff;
  logic [CW-1:0] len;
  logic [CW-1:0] len_m1;

  logic [CW-1:0] bits_r;
  logic [AW-1:0] x_r;
  logic [AW-1:0] w_r;
  logic          x_last;

  logic          a_v_r;
  logic          a_par_r;
  logic          a_last_r;
  logic          rd_bit;
  logic          miss;

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] sum_r;
  logic          b_v_r;

  logic [CW:0]   twice;
  logic [CW:0]   len_x;
  logic [CW:0]   mag_wide;
  logic [CW-1:0] mag;
  logic [CW-1:0] max_r;
  logic [CW-1:0] nl_wide;

  logic [MAX_VARS-1:0] nl_r;
  logic [MAX_VARS:0]   max_out_r;

  // Saturate the variable count into 1..MAX_VARS
  always_comb begin
    if (num_vars == '0) begin
      n_eff = NW'(1);
    end else if (int'(num_vars) > MAX_VARS) begin
      n_eff = NW'(MAX_VARS);
    end else begin
      n_eff = NW'(num_vars);
    end
  end

  assign len    = CW'(1) << n_eff;
  assign len_m1 = len - CW'(1);

  assign status.last_bit  = (bits_r + CW'(1)) >= len;
  assign x_last           = ({1'b0, x_r} == len_m1);
  assign status.scan_last = x_last && ({1'b0, w_r} == len_m1);
  assign status.idle      = !a_v_r && !b_v_r;

  wn_ram #(
    .WIDTH(1),
    .DEPTH(1 << MAX_VARS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (bits_r[AW-1:0]),
    .wdata (truth_bit),
    .raddr (x_r),
    .rdata (rd_bit)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        bits_r <= status.last_bit ? '0 : bits_r + CW'(1);
      end
      a_v_r <= cmd.step;
      b_v_r <= a_v_r && a_last_r;
    end
  end

  // Scan counters: x runs fastest, w advances after each full pass over x
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      x_r <= '0;
      w_r <= '0;
    end else if (cmd.step) begin
      if (x_last) begin
        x_r <= '0;
        w_r <= w_r + AW'(1);
      end else begin
        x_r <= x_r + AW'(1);
      end
    end
  end

  // Stage A: parity of w AND x travels alongside the table read
  always_ff @(posedge clk) begin
    a_par_r  <= ^(w_r & x_r);
    a_last_r <= x_last;
  end

  // Stage B: count disagreements between f(x) and the linear function
  assign miss = rd_bit ^ a_par_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      cnt_r <= '0;
    end else if (a_v_r) begin
      if (a_last_r) begin
        cnt_r <= '0;
        sum_r <= cnt_r + CW'(miss);
      end else begin
        cnt_r <= cnt_r + CW'(miss);
      end
    end
  end

  // Stage C: |W(w)| = |len - 2*count|, keep the largest
  assign twice    = {sum_r, 1'b0};
  assign len_x    = {1'b0, len};
  assign mag_wide = (twice >= len_x) ? (twice - len_x) : (len_x - twice);
  assign mag      = mag_wide[CW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      max_r <= '0;
    end else if (b_v_r && (mag > max_r)) begin
      max_r <= mag;
    end
  end

  assign nl_wide = (len >> 1) - (max_r >> 1);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      nl_r      <= nl_wide[MAX_VARS-1:0];
      max_out_r <= max_r;
    end
  end

  assign nonlinearity  = nl_r;
  assign max_abs_walsh = max_out_r;

endmodule

/* rtl/core/wn_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences table load, Walsh scan, drain and result hand-off.
// Depends on wn_pkg.
module wn_ctrl
  import wn_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   accept;

  assign in_stall = (state_r != ST_LOAD);
  assign accept   = in_valid && !in_stall;

  assign cmd.load      = accept;
  assign cmd.scan_init = accept && status.last_bit;
  assign cmd.step      = (state_r == ST_SCAN);
  // Hand off only once the pipeline is empty and the output slot frees up
  assign cmd.emit      = (state_r == ST_DRAIN) && status.idle &&
                         (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (cmd.scan_init) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (cmd.emit) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && out_stall))
    else $error("result overwritten while still stalled");

  a_load_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> status.idle)
    else $error("scan pipeline busy while loading");

  a_scan_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && status.scan_last) |=> (state_r == ST_DRAIN && !status.idle))
    else $error("final scan read not followed by drain");

  a_emit_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("result captured without valid");

endmodule

/* rtl/core/walsh_nonlinearity.sv */
`timescale 1ns / 1ps
// Top level of the Walsh nonlinearity block: configuration register and wiring.
// Depends on wn_pkg, wn_ctrl, wn_dp (and wn_ram through wn_dp).

// Truth-table bits stream in one per cycle while in_stall is low, in index order,
// into a 2^MAX_VARS x 1 RAM. The bit that completes a table of 2^n entries starts
// the spectrum scan: each coefficient W(w) is formed by one pass over x reading one
// table bit per cycle, and in_stall stays high through the scan, the pipeline drain
// and the hand-off, which waits while an earlier result is still stalled. The single
// RAM read port sets that rate. A finished result waits in the output register;
// loading of the next table goes on meanwhile. num_vars is saturated into 1..MAX_VARS
// and must be written only while the block is idle.
module walsh_nonlinearity
  import wn_pkg::*;
#(
  parameter int MAX_VARS = MAX_VARS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_truth_bit,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MAX_VARS-1:0]   out_nonlinearity,
  output logic [MAX_VARS:0]     out_max_abs_walsh,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [NUM_VARS_W-1:0] num_vars_r;
  logic                  cfg_wr;
  cmd_t                  cmd;
  status_t               status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r <= NUM_VARS_RST;
    end else if (cfg_wr && (paddr[2] == REG_NUM_VARS)) begin
      num_vars_r <= pwdata[NUM_VARS_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NUM_VARS: prdata = CFG_DATA_W'(num_vars_r);
      default:      prdata = '0;
    endcase
  end

  wn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  wn_dp #(
    .MAX_VARS(MAX_VARS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .num_vars      (num_vars_r),
    .truth_bit     (in_truth_bit),
    .cmd           (cmd),
    .status        (status),
    .nonlinearity  (out_nonlinearity),
    .max_abs_walsh (out_max_abs_walsh)
  );

endmodule

/* bench/walsh_nonlinearity_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for walsh_nonlinearity: streams truth tables, predicts each
// function's peak Walsh coefficient and nonlinearity, and compares every result.
// Depends on wn_pkg and the walsh_nonlinearity RTL only.
module walsh_nonlinearity_tb;
  import wn_pkg::*;

  localparam int NV            = MAX_VARS_DEF;
  localparam int TABLE_DEPTH   = 1 << NV;
  localparam int WIDE_VARS     = 9;
  localparam int RANDOM_ITEMS  = 400;
  localparam longint LIMIT_NS  = 64'd96_000_000;

  typedef struct packed {
    logic [NV-1:0] nl;
    logic [NV:0]   peak;
  } nl_score_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_BIT} row_kind_e;
  typedef enum logic [1:0] {SHAPE_NOISE, SHAPE_AFFINE, SHAPE_BENT, SHAPE_CONST} shape_e;

  typedef struct packed {
    row_kind_e     kind;
    logic [3:0]    value;
    logic          typed;
    logic [NV-1:0] want_nl;
    logic [NV:0]   want_peak;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_truth_bit;
  logic                  out_valid;
  logic                  out_stall;
  logic [NV-1:0]         out_nonlinearity;
  logic [NV:0]           out_max_abs_walsh;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Predictor state
  bit          table_mem [TABLE_DEPTH];
  int unsigned loaded_bits;
  logic [3:0]  cfg_vars;

  nl_score_t   awaited_scores [$];
  int unsigned errors;
  int unsigned bits_sent;
  int unsigned cfg_writes;
  int unsigned scores_checked;
  bit          in_calm;
  bit          out_calm;

  // Short directed walk: extremes of n, saturation, mid-table change of n.
  row_t plan [30] = '{
    '{ROW_CFG, 4'd1,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd0,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd0,  1'b1, 10'd0, 11'd2},
    '{ROW_BIT, 4'd0,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd1,  1'b1, 10'd0, 11'd2},
    '{ROW_CFG, 4'd0,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd1,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd0,  1'b1, 10'd0, 11'd2},
    '{ROW_CFG, 4'd2,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd0,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd0,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd0,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd1,  1'b1, 10'd1, 11'd2},
    '{ROW_CFG, 4'd15, 1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd1,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd0,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd1,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd1,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd0,  1'b0, 10'd0, 11'd0},
    '{ROW_CFG, 4'd2,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd1,  1'b1, 10'd1, 11'd2},
    '{ROW_CFG, 4'd3,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd1,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd1,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd1,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd1,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd1,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd1,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd1,  1'b0, 10'd0, 11'd0},
    '{ROW_BIT, 4'd1,  1'b1, 10'd0, 11'd8}
  };

  walsh_nonlinearity DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_truth_bit      (in_truth_bit),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_nonlinearity  (out_nonlinearity),
    .out_max_abs_walsh (out_max_abs_walsh),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned eff_vars();
    if (cfg_vars == 4'd0) return 1;
    if (cfg_vars > NV) return NV;
    return cfg_vars;
  endfunction

  // Fast butterfly over the polar table, then the peak magnitude.
  function automatic nl_score_t spectrum_peak(input int unsigned n);
    int          coeff [TABLE_DEPTH];
    int unsigned span, h, i, j, mag, best;
    int          a, b;
    nl_score_t   r;
    span = 1 << n;
    best = 0;
    for (i = 0; i < span; i++) coeff[i] = table_mem[i] ? -1 : 1;
    for (h = 1; h < span; h = h << 1) begin
      for (i = 0; i < span; i += h << 1) begin
        for (j = i; j < i + h; j++) begin
          a = coeff[j];
          b = coeff[j + h];
          coeff[j]     = a + b;
          coeff[j + h] = a - b;
        end
      end
    end
    for (i = 0; i < span; i++) begin
      mag = (coeff[i] < 0) ? -coeff[i] : coeff[i];
      if (mag > best) best = mag;
    end
    r.peak = best[NV:0];
    r.nl   = NV'((1 << (n - 1)) - (best >> 1));
    return r;
  endfunction

  // Append a prediction behind the ones still outstanding.
  task automatic queue_score(input nl_score_t s);
    awaited_scores.insert(awaited_scores.size(), s);
  endtask

  task automatic absorb_bit(input logic b, output bit fired, output nl_score_t s);
    int unsigned n;
    n = eff_vars();
    table_mem[loaded_bits % TABLE_DEPTH] = b;
    loaded_bits++;
    fired = (loaded_bits >= (1 << n));
    s = '0;
    if (fired) begin
      loaded_bits = 0;
      s = spectrum_peak(n);
    end
  endtask

  function automatic logic table_value(input shape_e shape, input int unsigned x,
                                       input int unsigned n, input int unsigned mask,
                                       input logic flip);
    int unsigned m;
    m = n / 2;
    case (shape)
      SHAPE_AFFINE: return (^(mask & x)) ^ flip;
      SHAPE_CONST:  return flip;
      SHAPE_BENT: begin
        // x.y over the two halves plus an affine term stays bent
        if (n % 2 == 0) return (^((x >> m) & x & ((1 << m) - 1))) ^ (^(mask & x)) ^ flip;
        return 1'($urandom_range(0, 1));
      end
      default:      return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Present one truth bit and hold it until the block takes it.
  task automatic send_bit(input logic b, output bit fired, output nl_score_t s);
    int unsigned gap;
    if (bits_sent % 40 == 0) in_calm = ($urandom_range(0, 3) == 0);
    gap = in_calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_truth_bit <= b;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    absorb_bit(b, fired, s);
    bits_sent++;
  endtask

  task automatic wait_drained();
    while (awaited_scores.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [CFG_DATA_W-1:0] wdata,
                          output logic [CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_NUM_VARS, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    rdata = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_num_vars(input logic [NUM_VARS_W-1:0] want);
    logic [CFG_DATA_W-1:0] rd;
    @(posedge clk);
    apb_xfer(1'b0, '0, rd);
    if (rd[NUM_VARS_W-1:0] !== want) begin
      $display("%0t: num_vars readback expected %0d got %0d", $time, want,
               rd[NUM_VARS_W-1:0]);
      errors++;
    end
  endtask

  // Release the input, let the block settle, then rewrite n and read it back.
  task automatic set_num_vars(input logic [CFG_DATA_W-1:0] word);
    logic [CFG_DATA_W-1:0] unused;
    in_valid <= 1'b0;
    wait_drained();
    apb_xfer(1'b1, word, unused);
    cfg_vars = word[3:0];
    cfg_writes++;
    check_num_vars(word[3:0]);
  endtask

  function automatic logic [CFG_DATA_W-1:0] vars_word(input logic [3:0] v);
    logic [CFG_DATA_W-1:0] w;
    w = $urandom;
    w[3:0] = v;
    return w;
  endfunction

  // Result sink: random stall ahead of each result, then compare with the oldest prediction.
  initial begin : result_sink
    int unsigned   gap;
    nl_score_t     want;
    logic [NV-1:0] got_nl;
    logic [NV:0]   got_peak;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (scores_checked % 6 == 0) out_calm = ($urandom_range(0, 3) == 0);
      gap = out_calm ? 0 : $urandom_range(0, 4);
      out_stall <= (gap != 0);
      if (gap != 0) begin
        do @(negedge clk); while (!out_valid);
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(negedge clk); while (!out_valid);
      got_nl   = out_nonlinearity;
      got_peak = out_max_abs_walsh;
      @(posedge clk);
      if (awaited_scores.size() == 0) begin
        $display("%0t: result with none expected (nonlinearity %0d, max_abs_walsh %0d)",
                 $time, got_nl, got_peak);
        errors++;
      end else begin
        want = awaited_scores.pop_front();
        if (got_nl !== want.nl) begin
          $display("%0t: nonlinearity expected %0d got %0d", $time, want.nl, got_nl);
          errors++;
        end
        if (got_peak !== want.peak) begin
          $display("%0t: max_abs_walsh expected %0d got %0d", $time, want.peak, got_peak);
          errors++;
        end
      end
      scores_checked++;
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    bit          fired;
    nl_score_t   s;
    int unsigned n, r, mask, goal, extra, k;
    logic        flip;
    shape_e      shape;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_truth_bit <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    loaded_bits  = 0;
    cfg_vars     = NUM_VARS_RST;
    errors       = 0;
    bits_sent    = 0;
    cfg_writes   = 0;
    scores_checked = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    check_num_vars(NUM_VARS_RST);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        set_num_vars({28'd0, plan[i].value});
      end else begin
        send_bit(plan[i].value[0], fired, s);
        if (plan[i].typed) queue_score({plan[i].want_nl, plan[i].want_peak});
        else if (fired) queue_score(s);
      end
    end

    // One wide table: an affine function gives the full-scale coefficient.
    set_num_vars(vars_word(4'(WIDE_VARS)));
    mask = $urandom_range(0, TABLE_DEPTH - 1);
    flip = 1'($urandom_range(0, 1));
    fired = 1'b0;
    while (!fired) begin
      send_bit(table_value(SHAPE_AFFINE, loaded_bits, WIDE_VARS, mask, flip), fired, s);
      if (fired) queue_score(s);
    end

    goal = bits_sent + RANDOM_ITEMS;
    while (bits_sent < goal) begin
      if ($urandom_range(0, 2) != 0) begin
        r = $urandom_range(0, 99);
        if (r < 6)       set_num_vars(vars_word(4'd0));
        else if (r < 70) set_num_vars(vars_word(4'($urandom_range(1, 4))));
        else if (r < 94) set_num_vars(vars_word(4'($urandom_range(5, 6))));
        else             set_num_vars(vars_word(4'd7));
      end
      r = $urandom_range(0, 99);
      shape = (r < 55) ? SHAPE_NOISE : (r < 72) ? SHAPE_AFFINE :
              (r < 88) ? SHAPE_BENT : SHAPE_CONST;
      mask = $urandom_range(0, TABLE_DEPTH - 1);
      flip = 1'($urandom_range(0, 1));
      fired = 1'b0;
      while (!fired) begin
        if (loaded_bits != 0 && $urandom_range(0, 99) < 3) begin
          // Break the table: park on a large n, push a few bits, drop back to a small n.
          set_num_vars(vars_word(4'($urandom_range(8, 15))));
          extra = $urandom_range(0, 4);
          for (k = 0; k < extra; k++) send_bit(1'($urandom_range(0, 1)), fired, s);
          set_num_vars(vars_word(4'($urandom_range(0, 5))));
          fired = 1'b0;
        end
        n = eff_vars();
        send_bit(table_value(shape, loaded_bits & ((1 << n) - 1), n, mask, flip), fired, s);
        if (fired) queue_score(s);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (16) @(posedge clk);
    $display("Streamed %0d truth-table bits with %0d writes of n (1 to %0d variables),",
             bits_sent, cfg_writes, NV);
    $display("checked %0d nonlinearity results, %0d mismatches", scores_checked, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/wn_pkg.sv
rtl/core/wn_ram.sv
rtl/core/wn_dp.sv
rtl/core/wn_ctrl.sv
rtl/core/walsh_nonlinearity.sv
bench/walsh_nonlinearity_tb.sv
